@@ src/assert_macros.svh @@
// assertion macros shared by the computed-table cache rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ src/bdct_pkg.sv @@
// types and constants of the bdd computed-table cache
// no dependencies; used by the top level
package bdct_pkg;

  // field widths
  localparam int unsigned REF_W      = 32;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned OPC_W      = 8;
  localparam int unsigned OPN_W      = 2;
  localparam int unsigned SLOT_OUT_W = 10;
  localparam int unsigned EPOCH_W    = 8;

  // hash shift amounts
  localparam int unsigned HASH_SH_HI = 4;
  localparam int unsigned HASH_SH_LO = 5;

  // request operations
  localparam logic [OPN_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OPN_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPN_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [OPN_W-1:0] operation;
    logic [REF_W-1:0] high_ref;
    logic [REF_W-1:0] low_ref;
    logic [IDX_W-1:0] high_index;
    logic [IDX_W-1:0] low_index;
    logic [OPC_W-1:0] op_code;
    logic [REF_W-1:0] store_ref;
  } in_req_t;

  typedef struct packed {
    logic                  hit;
    logic [REF_W-1:0]      found_ref;
    logic [SLOT_OUT_W-1:0] slot;
  } out_rsp_t;

  // one table entry as held in memory
  typedef struct packed {
    logic               valid;
    logic [EPOCH_W-1:0] epoch;
    logic [OPC_W-1:0]   op;
    logic [REF_W-1:0]   high;
    logic [REF_W-1:0]   low;
    logic [REF_W-1:0]   result;
  } entry_t;

  typedef enum logic {
    ST_SWEEP,
    ST_RUN
  } ctl_state_t;

endpackage

@@ src/bdct_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies; read during write to the same address returns old data
module bdct_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/bdd_computed_table_cache.sv @@
// Direct-mapped cache of BDD operation results (lookup, insert, clear-all).
// Each request reads its slot from one table memory in the cycle after it is
// accepted, compares the key and writes back on insert; its response then moves
// to an output register once that register is free. One request is taken per
// cycle while responses are drained, with a same-slot insert forwarded to the
// request right behind it. A clear bumps an 8-bit epoch held with every entry
// and blocks the next request until it has moved to the output register; after
// reset, and on every clear that wraps the epoch, a clearing pass writes all
// TABLE_DEPTH entries, one per cycle, during which no request is taken. The
// user must keep TABLE_DEPTH a power of two; the block does not enforce it.
// Depends on bdct_pkg, bdct_ram and assert_macros.svh.
`include "assert_macros.svh"

module bdd_computed_table_cache #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bdct_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output bdct_pkg::out_rsp_t out_rsp
);

  localparam int unsigned SLOT_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned ENTRY_W = $bits(bdct_pkg::entry_t);

  // control state
  bdct_pkg::ctl_state_t state_r, state_nxt;
  logic [SLOT_W-1:0]            sweep_addr_r, sweep_addr_nxt;
  logic [bdct_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;

  // lookup stage and output register
  logic               s1_valid_r, s1_valid_nxt;
  bdct_pkg::in_req_t  s1_req_r;
  logic [SLOT_W-1:0]  s1_slot_r;
  logic               fwd_r;
  bdct_pkg::entry_t   fwd_entry_r;
  logic               out_valid_r, out_valid_nxt;
  bdct_pkg::out_rsp_t out_r;

  logic               run_mode;
  logic               out_free;
  logic               s1_adv;
  logic               s1_clear;
  logic               s1_insert;
  logic               in_acc;
  logic               wrap_clear;
  logic               sweep_last;

  logic [bdct_pkg::REF_W-1:0]                hr_sh;
  logic [bdct_pkg::REF_W-1:0]                lr_sh;
  logic [SLOT_W+bdct_pkg::IDX_W-1:0]         hi_ext;
  logic [SLOT_W+bdct_pkg::IDX_W-1:0]         li_ext;
  logic [SLOT_W-1:0]                         in_slot;
  logic [SLOT_W+bdct_pkg::SLOT_OUT_W-1:0]    slot_ext;

  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  bdct_pkg::entry_t     ins_entry;
  bdct_pkg::entry_t     cur_entry;
  logic                 key_match;
  bdct_pkg::out_rsp_t   rsp;

  // slot hash, only the low slot bits of the sum matter
  assign hr_sh  = in_req.high_ref >> bdct_pkg::HASH_SH_HI;
  assign lr_sh  = in_req.low_ref >> bdct_pkg::HASH_SH_LO;
  assign hi_ext = (SLOT_W + bdct_pkg::IDX_W)'(in_req.high_index);
  assign li_ext = (SLOT_W + bdct_pkg::IDX_W)'(in_req.low_index);
  assign in_slot = in_req.high_ref[SLOT_W-1:0] + in_req.low_ref[SLOT_W-1:0]
                 + hr_sh[SLOT_W-1:0] + lr_sh[SLOT_W-1:0]
                 + hi_ext[SLOT_W-1:0] + li_ext[SLOT_W-1:0];

  // handshake and pipeline advance
  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign s1_clear  = (s1_req_r.operation == bdct_pkg::OP_CLEAR);
  assign s1_insert = (s1_req_r.operation == bdct_pkg::OP_INSERT);
  assign wrap_clear = s1_adv && s1_clear && (epoch_r == '1);
  assign sweep_last = (sweep_addr_r == SLOT_W'(TABLE_DEPTH - 1));
  assign in_ready  = run_mode && !(s1_valid_r && s1_clear) && (!s1_valid_r || out_free);
  assign in_acc    = in_valid && in_ready;

  // fsm next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdct_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_nxt = bdct_pkg::ST_RUN;
        end
      end
      bdct_pkg::ST_RUN: begin
        if (wrap_clear) begin
          state_nxt = bdct_pkg::ST_SWEEP;
        end
      end
      default: state_nxt = bdct_pkg::ST_SWEEP;
    endcase
  end

  // fsm outputs
  always_comb begin
    run_mode       = 1'b0;
    sweep_addr_nxt = '0;
    case (state_r)
      bdct_pkg::ST_SWEEP: begin
        sweep_addr_nxt = sweep_addr_r + 1'b1;
      end
      bdct_pkg::ST_RUN: begin
        run_mode = 1'b1;
      end
      default: begin
        run_mode = 1'b0;
      end
    endcase
  end

  // epoch bump on clear
  assign epoch_nxt = (s1_adv && s1_clear) ? epoch_r + 1'b1 : epoch_r;

  // entry written by an insert
  always_comb begin
    ins_entry.valid  = 1'b1;
    ins_entry.epoch  = epoch_r;
    ins_entry.op     = s1_req_r.op_code;
    ins_entry.high   = s1_req_r.high_ref;
    ins_entry.low    = s1_req_r.low_ref;
    ins_entry.result = s1_req_r.store_ref;
  end

  // write port: clearing pass or insert write-back
  always_comb begin
    if (!run_mode) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_adv && s1_insert;
      ram_waddr = s1_slot_r;
      ram_wdata = ins_entry;
    end
  end

  bdct_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_slot),
    .rdata (ram_rdata)
  );

  // key compare with forwarded entry when the previous request wrote this slot
  assign cur_entry = fwd_r ? fwd_entry_r : bdct_pkg::entry_t'(ram_rdata);
  assign key_match = cur_entry.valid && (cur_entry.epoch == epoch_r)
                  && (cur_entry.op == s1_req_r.op_code)
                  && (cur_entry.high == s1_req_r.high_ref)
                  && (cur_entry.low == s1_req_r.low_ref);
  assign slot_ext = (SLOT_W + bdct_pkg::SLOT_OUT_W)'(s1_slot_r);

  // response
  always_comb begin
    rsp.hit       = (s1_req_r.operation == bdct_pkg::OP_LOOKUP) && key_match;
    rsp.found_ref = rsp.hit ? cur_entry.result : '0;
    rsp.slot      = slot_ext[bdct_pkg::SLOT_OUT_W-1:0];
  end

  // valid flags
  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bdct_pkg::ST_SWEEP;
      sweep_addr_r <= '0;
      epoch_r      <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      fwd_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      epoch_r      <= epoch_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (in_acc) begin
        fwd_r <= s1_adv && s1_insert && (s1_slot_r == in_slot);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r    <= in_req;
      s1_slot_r   <= in_slot;
      fwd_entry_r <= ins_entry;
    end
    if (s1_adv) begin
      out_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  // checks
  `ASSERT_NEVER(a_no_req_in_sweep, clk, rst_n, (state_r == bdct_pkg::ST_SWEEP) && s1_valid_r)
  `ASSERT_PROP(a_acc_loads_s1, clk, rst_n, in_acc |=> s1_valid_r)
  `ASSERT_PROP(a_adv_loads_out, clk, rst_n, s1_adv |=> out_valid_r)
  `ASSERT_PROP(a_wrap_sweeps, clk, rst_n, wrap_clear |=> (state_r == bdct_pkg::ST_SWEEP))
  `ASSERT_NEVER(a_hit_only_lookup, clk, rst_n, s1_valid_r && rsp.hit && s1_insert)

endmodule

@@ tb/bdd_computed_table_cache_test.sv @@
// self-checking testbench for the bdd computed-table cache
// depends on bdct_pkg and bdd_computed_table_cache; drives random and directed requests
`timescale 1ns / 1ps

module bdd_computed_table_cache_test;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned POOL_MAX = 48;
  localparam int unsigned MAX_PRINTS = 50;
  // operation code with no defined meaning
  localparam logic [bdct_pkg::OPN_W-1:0] OP_RESERVED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  bdct_pkg::in_req_t  in_req = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bdct_pkg::out_rsp_t out_rsp;

  // mirror of the cache contents
  logic                       tbl_valid [TABLE_DEPTH];
  logic [bdct_pkg::OPC_W-1:0] tbl_op [TABLE_DEPTH];
  logic [bdct_pkg::REF_W-1:0] tbl_high [TABLE_DEPTH];
  logic [bdct_pkg::REF_W-1:0] tbl_low [TABLE_DEPTH];
  logic [bdct_pkg::REF_W-1:0] tbl_result [TABLE_DEPTH];

  bdct_pkg::out_rsp_t pending_rsp[$];
  bdct_pkg::in_req_t  key_pool[$];

  int unsigned mismatch_count = 0;
  int unsigned req_count = 0;
  int unsigned rsp_count = 0;
  int unsigned hit_count = 0;
  int unsigned clear_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b0;
  bit          hold_off_req = 1'b0;

  bdd_computed_table_cache #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  always #2 clk = ~clk;

  initial begin
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
  end

  // hash, key compare and table update for one request
  function automatic bdct_pkg::out_rsp_t predict_cache_rsp(bdct_pkg::in_req_t req);
    logic [63:0] hash_sum;
    int unsigned s;
    bdct_pkg::out_rsp_t rsp;
    hash_sum = 64'(req.high_ref) + 64'(req.low_ref)
             + 64'(req.high_ref >> bdct_pkg::HASH_SH_HI)
             + 64'(req.low_ref >> bdct_pkg::HASH_SH_LO)
             + 64'(req.high_index) + 64'(req.low_index);
    s = int'(hash_sum % TABLE_DEPTH);
    rsp = '0;
    rsp.slot = bdct_pkg::SLOT_OUT_W'(s);
    case (req.operation)
      bdct_pkg::OP_LOOKUP: begin
        if (tbl_valid[s] && tbl_op[s] == req.op_code && tbl_high[s] == req.high_ref &&
            tbl_low[s] == req.low_ref) begin
          rsp.hit = 1'b1;
          rsp.found_ref = tbl_result[s];
        end
      end
      bdct_pkg::OP_INSERT: begin
        tbl_valid[s] = 1'b1;
        tbl_op[s] = req.op_code;
        tbl_high[s] = req.high_ref;
        tbl_low[s] = req.low_ref;
        tbl_result[s] = req.store_ref;
      end
      bdct_pkg::OP_CLEAR: begin
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch on %s at response %0d: got %0h, expected %0h", what, rsp_count, got,
               want);
  endtask

  // response check and request capture, both on the rising edge
  always @(posedge clk) begin : watch_ports
    bdct_pkg::out_rsp_t want;
    cycle_count++;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected response", 64'(out_rsp), 64'd0);
        end else begin
          want = pending_rsp.pop_front();
          if (out_rsp.hit !== want.hit)
            report_mismatch("hit", 64'(out_rsp.hit), 64'(want.hit));
          if (out_rsp.found_ref !== want.found_ref)
            report_mismatch("found_ref", 64'(out_rsp.found_ref), 64'(want.found_ref));
          if (out_rsp.slot !== want.slot)
            report_mismatch("slot", 64'(out_rsp.slot), 64'(want.slot));
          if (want.hit) hit_count++;
        end
        rsp_count++;
      end
      if (in_valid && in_ready) begin
        pending_rsp.push_back(predict_cache_rsp(in_req));
        req_count++;
        if (in_req.operation == bdct_pkg::OP_CLEAR) clear_count++;
      end
    end
  end

  // result side: random stall patterns in phases of random length, plus a long hold-off
  initial begin : drive_out_ready
    int mode;
    int phase_left;
    int hold;
    mode = 0;
    phase_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        hold = $urandom_range(300, 400);
        repeat (hold) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 3);
          phase_left = $urandom_range(16, 96);
        end
        phase_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (phase_left % 5 != 0);
        endcase
      end
    end
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // offer one request, in bursts with random gaps when enabled
  task automatic send_request(bdct_pkg::in_req_t req);
    int gap;
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 24);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait for every pending response
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic bdct_pkg::in_req_t make_req(logic [bdct_pkg::OPN_W-1:0] operation,
                                                 logic [bdct_pkg::REF_W-1:0] hr,
                                                 logic [bdct_pkg::REF_W-1:0] lr,
                                                 logic [bdct_pkg::IDX_W-1:0] hi,
                                                 logic [bdct_pkg::IDX_W-1:0] li,
                                                 logic [bdct_pkg::OPC_W-1:0] opc,
                                                 logic [bdct_pkg::REF_W-1:0] sr);
    bdct_pkg::in_req_t req;
    req.operation = operation;
    req.high_ref = hr;
    req.low_ref = lr;
    req.high_index = hi;
    req.low_index = li;
    req.op_code = opc;
    req.store_ref = sr;
    return req;
  endfunction

  // references biased toward the extremes
  function automatic logic [bdct_pkg::REF_W-1:0] rand_ref();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return bdct_pkg::REF_W'($urandom_range(0, 255));
      default: return bdct_pkg::REF_W'($urandom);
    endcase
  endfunction

  function automatic logic [bdct_pkg::IDX_W-1:0] rand_index();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return bdct_pkg::IDX_W'($urandom);
    endcase
  endfunction

  function automatic bdct_pkg::in_req_t rand_key(logic [bdct_pkg::OPN_W-1:0] operation);
    return make_req(operation, rand_ref(), rand_ref(), rand_index(), rand_index(),
                    bdct_pkg::OPC_W'($urandom_range(0, 255)), rand_ref());
  endfunction

  function automatic void remember_key(bdct_pkg::in_req_t req);
    key_pool.push_back(req);
    if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
  endfunction

  // mostly inserts and lookups of known keys, some misses, collisions, clears and noise
  function automatic bdct_pkg::in_req_t random_request();
    bdct_pkg::in_req_t req;
    int pick;
    pick = $urandom_range(0, 99);
    if (key_pool.size() == 0 && pick >= 30 && pick < 94) pick = 0;
    if (pick >= 30 && pick < 94) req = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (pick < 30) begin
      req = rand_key(bdct_pkg::OP_INSERT);
      remember_key(req);
    end else if (pick < 65) begin
      req.operation = bdct_pkg::OP_LOOKUP;
    end else if (pick < 70) begin
      // one key field off by a bit
      req.operation = bdct_pkg::OP_LOOKUP;
      case ($urandom_range(0, 2))
        0: req.op_code ^= bdct_pkg::OPC_W'(1) << $urandom_range(0, bdct_pkg::OPC_W - 1);
        1: req.high_ref ^= bdct_pkg::REF_W'(1) << $urandom_range(0, bdct_pkg::REF_W - 1);
        default: req.low_ref ^= bdct_pkg::REF_W'(1) << $urandom_range(0, bdct_pkg::REF_W - 1);
      endcase
    end else if (pick < 75) begin
      // indexes shifted against each other: same slot, same key
      req.operation = bdct_pkg::OP_LOOKUP;
      if (req.high_index != '1 && req.low_index != '0) begin
        req.high_index++;
        req.low_index--;
      end
    end else if (pick < 85) begin
      req = rand_key(bdct_pkg::OP_LOOKUP);
    end else if (pick < 90) begin
      // other key into the same slot
      req.operation = bdct_pkg::OP_INSERT;
      req.op_code++;
      req.store_ref = rand_ref();
      remember_key(req);
    end else if (pick < 94) begin
      req.operation = bdct_pkg::OP_INSERT;
      req.store_ref = rand_ref();
    end else if (pick < 97) begin
      req = rand_key(bdct_pkg::OP_CLEAR);
    end else begin
      req = rand_key(OP_RESERVED);
    end
    return req;
  endfunction

  task automatic test_directed();
    bdct_pkg::in_req_t key_a;
    bdct_pkg::in_req_t key_b;
    bdct_pkg::in_req_t req;
    gaps_on = 1'b0;
    key_a = make_req(bdct_pkg::OP_INSERT, 32'h1234_5678, 32'h9abc_def0, 16'd100, 16'd200,
                     8'h11, 32'ha5a5_0001);
    key_b = key_a;
    key_b.op_code = 8'h22;
    key_b.store_ref = 32'ha5a5_0002;
    // empty table, all-zero and all-one keys
    send_request(make_req(bdct_pkg::OP_LOOKUP, '0, '0, '0, '0, '0, '0));
    send_request(make_req(bdct_pkg::OP_INSERT, '1, '1, '1, '1, '1, '1));
    send_request(make_req(bdct_pkg::OP_LOOKUP, '1, '1, '1, '1, '1, '0));
    send_request(make_req(bdct_pkg::OP_LOOKUP, '1, '1, '1, '1, 8'hfe, '0));
    send_request(make_req(bdct_pkg::OP_INSERT, '0, '0, '0, '0, '0, '0));
    send_request(make_req(bdct_pkg::OP_LOOKUP, '0, '0, '0, '0, '0, '1));
    send_request(make_req(bdct_pkg::OP_LOOKUP, 32'd1, '0, '0, '0, '0, '0));
    // two keys on one slot, differing only in op code
    send_request(key_a);
    send_request(key_b);
    key_a.operation = bdct_pkg::OP_LOOKUP;
    key_b.operation = bdct_pkg::OP_LOOKUP;
    send_request(key_a);
    send_request(key_b);
    req = key_b;
    req.high_index = 16'd101;
    req.low_index = 16'd199;
    send_request(req);
    // same slot but different high reference
    req = key_b;
    req.high_ref = key_b.high_ref + 32'd16;
    req.high_index = 16'd83;
    send_request(req);
    req = key_b;
    req.low_ref = key_b.low_ref ^ 32'h8000_0000;
    send_request(req);
    // undefined operation leaves the table alone
    send_request(make_req(OP_RESERVED, '1, '1, '1, '1, '1, '0));
    send_request(make_req(bdct_pkg::OP_LOOKUP, '1, '1, '1, '1, '1, '0));
    // clear drops everything, insert works again afterwards
    send_request(make_req(bdct_pkg::OP_CLEAR, '1, '1, '1, '1, '1, '1));
    send_request(make_req(bdct_pkg::OP_LOOKUP, '1, '1, '1, '1, '1, '0));
    send_request(key_b);
    key_b.operation = bdct_pkg::OP_INSERT;
    send_request(key_b);
    key_b.operation = bdct_pkg::OP_LOOKUP;
    send_request(key_b);
    wait_idle();
  endtask

  // enough clears to wrap the entry epoch, with inserts and lookups around them
  task automatic test_clear_epoch_wrap();
    bdct_pkg::in_req_t fresh;
    bdct_pkg::in_req_t older;
    bit                have_older;
    gaps_on = 1'b1;
    have_older = 1'b0;
    for (int i = 0; i < 264; i++) begin
      send_request(rand_key(bdct_pkg::OP_CLEAR));
      if (i % 8 == 0) begin
        if (have_older) send_request(older);
        fresh = rand_key(bdct_pkg::OP_INSERT);
        send_request(fresh);
        fresh.operation = bdct_pkg::OP_LOOKUP;
        send_request(fresh);
        older = fresh;
        have_older = 1'b1;
      end
    end
    wait_idle();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    bdct_pkg::in_req_t req;
    gaps_on = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 64; i++) begin
      if (i % 2 == 0) begin
        req = rand_key(bdct_pkg::OP_INSERT);
        remember_key(req);
      end else begin
        req = key_pool[$urandom_range(0, key_pool.size() - 1)];
        req.operation = bdct_pkg::OP_LOOKUP;
      end
      send_request(req);
    end
    wait_idle();
  endtask

  task automatic test_random();
    gaps_on = 1'b1;
    repeat (RANDOM_ITEMS) send_request(random_request());
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_clear_epoch_wrap();
    test_backpressure();
    test_random();
    repeat (20) @(posedge clk);
    if (pending_rsp.size() != 0)
      report_mismatch("responses never delivered", 64'(pending_rsp.size()), 64'd0);
    $display("covered %0d requests with %0d responses: %0d lookup hits, %0d clears",
             req_count, rsp_count, hit_count, clear_count);
    $display("%0d cycles, %0d mismatches", cycle_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
